### sv/lha_pkg.sv
// ----------------------------------------------------------------------------
// lha_pkg
// Shared types, constants and register indexes of the line Hough accumulator.
// ----------------------------------------------------------------------------
package lha_pkg;

   // default sizes of the vote store
   localparam int DefSlopeBins     = 2048;
   localparam int DefInterceptBins = 256;
   localparam int DefCountBits     = 16;

   // field widths of the streams and registers
   localparam int CoordW     = 16;
   localparam int SlopeBinW  = 11;
   localparam int IcptBinW   = 8;
   localparam int CountOutW  = 16;
   localparam int CsrIndexW  = 2;
   localparam int CsrDataW   = 24;
   localparam int ReqDataW   = 56;

   // register reset values
   localparam logic signed [23:0] SlopeLowReset  = -24'sd6553600;
   localparam logic [22:0]        SlopeStepReset = 23'd6554;
   localparam logic signed [15:0] IcptLowReset   = -16'sd2560;
   localparam logic [15:0]        IcptScaleReset = 16'd2560;

   // register indexes
   localparam logic [CsrIndexW-1:0] CSR_SLOPE_LOW  = 2'd0;
   localparam logic [CsrIndexW-1:0] CSR_SLOPE_STEP = 2'd1;
   localparam logic [CsrIndexW-1:0] CSR_ICPT_LOW   = 2'd2;
   localparam logic [CsrIndexW-1:0] CSR_ICPT_SCALE = 2'd3;

   // opcodes on the request stream
   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   typedef enum logic [1:0] {
      CMD_ADD,
      CMD_READ,
      CMD_CLEAR
   } lha_kind_type;

   // one queued command
   typedef struct packed {
      lha_kind_type              kind;
      logic signed [CoordW-1:0]  hit_x;
      logic signed [CoordW-1:0]  hit_y;
      logic [SlopeBinW-1:0]      slope_bin;
      logic [IcptBinW-1:0]       intercept_bin;
      logic                      out_of_range;
   } lha_cmd_type;

   // configuration register file contents
   typedef struct packed {
      logic signed [23:0] slope_low;
      logic [22:0]        slope_step;
      logic signed [15:0] intercept_low;
      logic [15:0]        intercept_scale;
   } lha_cfg_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_PRELOAD,
      ST_SWEEP,
      ST_READ,
      ST_READ_WAIT
   } lha_state_type;

endpackage

### sv/lha_ram.sv
// ----------------------------------------------------------------------------
// lha_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lha_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### sv/lha_front.sv
// ----------------------------------------------------------------------------
// lha_front
// Request intake: decodes the opcode, drops unused opcodes, range-checks reads, two-entry queue.
// ----------------------------------------------------------------------------
module lha_front import lha_pkg::*; #(
   parameter int SLOPE_BINS     = DefSlopeBins,
   parameter int INTERCEPT_BINS = DefInterceptBins
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,
   input  logic [1:0]          req_tuser,
   output logic                q_valid,
   output lha_cmd_type         q_head,
   input  logic                q_pop
);

   lha_cmd_type entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   lha_cmd_type cmd;
   logic        keep;
   logic        push;
   logic        pop;

   // classify the request
   always_comb begin
      cmd.hit_x         = req_tdata[15:0];
      cmd.hit_y         = req_tdata[31:16];
      cmd.slope_bin     = req_tdata[42:32];
      cmd.intercept_bin = req_tdata[50:43];
      cmd.out_of_range  = (32'(cmd.slope_bin) >= SLOPE_BINS) ||
                          (32'(cmd.intercept_bin) >= INTERCEPT_BINS);
      keep = 1'b1;
      case (req_tuser)
         OP_ADD:   cmd.kind = CMD_ADD;
         OP_READ:  cmd.kind = CMD_READ;
         OP_CLEAR: cmd.kind = CMD_CLEAR;
         default: begin
            cmd.kind = CMD_ADD;
            keep     = 1'b0;
         end
      endcase
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready && keep;
   assign pop        = q_pop && q_valid;
   assign q_valid    = (count_ff != 2'd0);
   assign q_head     = entry_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

### sv/lha_engine.sv
// ----------------------------------------------------------------------------
// lha_engine
// Command execution: slope sweep pipeline, cell reads and store clearing.
// ----------------------------------------------------------------------------
module lha_engine import lha_pkg::*; #(
   parameter int SLOPE_BINS     = DefSlopeBins,
   parameter int INTERCEPT_BINS = DefInterceptBins,
   parameter int COUNT_BITS     = DefCountBits
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lha_cfg_type          cfg,
   input  logic                 q_valid,
   input  lha_cmd_type          q_head,
   output logic                 q_pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [CountOutW-1:0] rsp_tdata
);

   localparam int SBW   = $clog2(SLOPE_BINS);
   localparam int IBW   = $clog2(INTERCEPT_BINS);
   localparam int AW    = SBW + IBW;
   localparam int DEPTH = SLOPE_BINS << IBW;
   localparam int DW    = SBW + 42;
   localparam int UDW   = 43;
   localparam int PW    = UDW + 16;
   localparam logic [COUNT_BITS-1:0] CountMax = '1;

   lha_state_type       state_ff, state_in;
   logic [AW-1:0]       clr_cnt_ff, clr_cnt_in;
   logic [SBW-1:0]      j_ff, j_in;
   lha_cmd_type         cmd_ff;
   logic signed [39:0]  kx0_ff, kx0_in;
   logic signed [39:0]  dstep_ff, dstep_in;
   logic signed [DW-1:0] d_ff, d_in;
   logic signed [16:0]  ydiff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CountOutW-1:0] rsp_data_ff, rsp_data_in;
   logic                sweep_go;
   logic                load_cmd;

   // pipeline stage registers
   logic                s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic [SBW-1:0]      s1_j_ff, s2_j_ff;
   logic                s1_neg_ff, s1_big_ff, s2_neg_ff, s2_big_ff;
   logic [UDW-1:0]      s1_ud_ff;
   logic [PW-1:0]       s2_prod_ff;
   logic [AW-1:0]       s3_addr_ff, s4_addr_ff;
   logic                vote;
   logic [IBW-1:0]      vote_bin;
   logic                pipe_empty;

   // memory port signals
   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [COUNT_BITS-1:0] ram_wdata;
   logic [AW-1:0]       ram_raddr;
   logic [COUNT_BITS-1:0] ram_rdata;
   logic [AW-1:0]       read_addr;
   logic [12:0]         sb_ext;
   logic [10:0]         ib_ext;

   assign pipe_empty = !(s1_valid_ff || s2_valid_ff || s3_valid_ff || s4_valid_ff);
   assign sb_ext     = 13'(cmd_ff.slope_bin);
   assign ib_ext     = 11'(cmd_ff.intercept_bin);
   assign read_addr  = {sb_ext[SBW-1:0], ib_ext[IBW-1:0]};
   assign ydiff      = 17'(cmd_ff.hit_y) - 17'(cfg.intercept_low);

   // sequencer: next state and control
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      j_in         = j_ff;
      kx0_in       = cfg.slope_low * cmd_ff.hit_x;
      dstep_in     = $signed({1'b0, cfg.slope_step}) * cmd_ff.hit_x;
      d_in         = d_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      load_cmd     = 1'b0;
      sweep_go     = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid && (q_head.kind == CMD_ADD || pipe_empty)) begin
               q_pop    = 1'b1;
               load_cmd = 1'b1;
               case (q_head.kind)
                  CMD_ADD:   state_in = ST_SETUP;
                  CMD_READ:  state_in = ST_READ;
                  CMD_CLEAR: begin
                     state_in   = ST_CLEAR;
                     clr_cnt_in = '0;
                  end
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_SETUP: begin
            state_in = ST_PRELOAD;
         end
         ST_PRELOAD: begin
            d_in     = (DW'(ydiff) <<< 16) - DW'(kx0_ff);
            j_in     = '0;
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            sweep_go = 1'b1;
            d_in     = d_ff - DW'(dstep_ff);
            j_in     = j_ff + 1'b1;
            if (j_ff == SBW'(SLOPE_BINS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            if (!rsp_valid_ff) begin
               if (cmd_ff.out_of_range) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_READ_WAIT;
               end
            end
         end
         ST_READ_WAIT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = CountOutW'(ram_rdata);
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_valid_ff  <= sweep_go;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff && vote;
         s4_valid_ff  <= s3_valid_ff;
      end
   end

   // sweep datapath and held command
   always_ff @(posedge clock) begin
      if (load_cmd) begin
         cmd_ff <= q_head;
      end
      kx0_ff      <= kx0_in;
      dstep_ff    <= dstep_in;
      d_ff        <= d_in;
      j_ff        <= j_in;
      rsp_data_ff <= rsp_data_in;
   end

   // stage 1: sign and magnitude of the offset
   always_ff @(posedge clock) begin
      s1_j_ff   <= j_ff;
      s1_neg_ff <= d_ff[DW-1];
      s1_big_ff <= |d_ff[DW-2:UDW];
      s1_ud_ff  <= d_ff[UDW-1:0];
   end

   // stage 2: scale the offset
   always_ff @(posedge clock) begin
      s2_j_ff    <= s1_j_ff;
      s2_neg_ff  <= s1_neg_ff;
      s2_big_ff  <= s1_big_ff;
      s2_prod_ff <= PW'(s1_ud_ff) * PW'(cfg.intercept_scale);
   end

   // stage 3: bin select and range check
   always_comb begin
      if (cfg.intercept_scale == 16'd0) begin
         vote     = 1'b1;
         vote_bin = '0;
      end else begin
         vote     = !s2_neg_ff && !s2_big_ff &&
                    (s2_prod_ff[PW-1:32] < (PW-32)'(INTERCEPT_BINS));
         vote_bin = s2_prod_ff[32+IBW-1:32];
      end
   end

   always_ff @(posedge clock) begin
      s3_addr_ff <= {s2_j_ff, vote_bin};
      s4_addr_ff <= s3_addr_ff;
   end

   // memory port selection
   always_comb begin
      ram_raddr = s3_valid_ff ? s3_addr_ff : read_addr;
      if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_cnt_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = s4_valid_ff;
         ram_waddr = s4_addr_ff;
         ram_wdata = (ram_rdata == CountMax) ? ram_rdata : ram_rdata + 1'b1;
      end
   end

   lha_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### sv/line_hough_accumulator.sv
// ----------------------------------------------------------------------------
// line_hough_accumulator
// Slope-intercept Hough vote store with hit, read and clear commands.
// ----------------------------------------------------------------------------
// An add-hit command occupies the sweep engine from the cycle it leaves the
// queue through setup, preload and a sweep of all SLOPE_BINS slope bins: the
// engine steps one slope bin per cycle through a pipelined read-modify-write
// of the single vote memory. A read waits until earlier votes have drained
// from the 4-stage pipeline; an out-of-range cell answers zero. A clear, and
// the pass that follows reset, writes zero to one cell per cycle, covering
// SLOPE_BINS times the intercept bins rounded up to a power of two cells
// (524288 by default); no command runs during it, while register writes are
// taken as ever. Up to two commands queue ahead of the engine.
module line_hough_accumulator import lha_pkg::*; #(
   parameter int SLOPE_BINS     = DefSlopeBins,
   parameter int INTERCEPT_BINS = DefInterceptBins,
   parameter int COUNT_BITS     = DefCountBits
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // hit_x, hit_y, read_slope_bin, read_intercept_bin, zero fill
   input  logic [ReqDataW-1:0]  req_tdata,
   // opcode
   input  logic [1:0]           req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // cell_count
   output logic [CountOutW-1:0] rsp_tdata,
   input  logic                 csr_we,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_data
);

   lha_cfg_type cfg_ff, cfg_in;
   logic        q_valid;
   lha_cmd_type q_head;
   logic        q_pop;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SLOPE_LOW:  cfg_in.slope_low       = csr_data;
            CSR_SLOPE_STEP: cfg_in.slope_step      = csr_data[22:0];
            CSR_ICPT_LOW:   cfg_in.intercept_low   = csr_data[15:0];
            CSR_ICPT_SCALE: cfg_in.intercept_scale = csr_data[15:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slope_low       <= SlopeLowReset;
         cfg_ff.slope_step      <= SlopeStepReset;
         cfg_ff.intercept_low   <= IcptLowReset;
         cfg_ff.intercept_scale <= IcptScaleReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lha_front #(
      .SLOPE_BINS     (SLOPE_BINS),
      .INTERCEPT_BINS (INTERCEPT_BINS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop)
   );

   lha_engine #(
      .SLOPE_BINS     (SLOPE_BINS),
      .INTERCEPT_BINS (INTERCEPT_BINS),
      .COUNT_BITS     (COUNT_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the line Hough accumulator: request and result
// streams with random idling, a vote store model checked on every cell read,
// and register settings swept between phases.
// ----------------------------------------------------------------------------
module tb;
   import lha_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int NumIcpt = DefInterceptBins;

   // one pending request; hot picks a recently voted cell when it is sent
   typedef struct {
      logic [1:0]               op;
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
      logic [SlopeBinW-1:0]     sb;
      logic [IcptBinW-1:0]      ib;
      bit                       hot;
   } hough_req_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [ReqDataW-1:0]  req_tdata = '0;
   logic [1:0]           req_tuser = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [CountOutW-1:0] rsp_tdata;
   logic                 csr_we = 1'b0;
   logic [CsrIndexW-1:0] csr_index = '0;
   logic [CsrDataW-1:0]  csr_data = '0;

   // model copy of registers and vote store
   logic signed [23:0] m_slope_low;
   logic [22:0]        m_slope_step;
   logic signed [15:0] m_icpt_low;
   logic [15:0]        m_icpt_scale;
   logic [15:0]        vote_mem [int];
   int                 voted_cells [$];

   hough_req_type      pending_q [$];
   logic [15:0]        count_q [$];
   int                 fails = 0;
   int                 xfer_count = 0;
   bit                 hold_go = 1'b0;
   bit                 hold_armed = 1'b0;
   int                 hold_left = 0;
   bit                 calm;

   line_hough_accumulator dut (.*);

   always #2 clock = ~clock;

   assign calm = (xfer_count >= 120) && (xfer_count < 175);

   // sweep all slope bins for one hit and bump the cells it lands in
   task automatic cast_votes(input logic signed [15:0] hx, input logic signed [15:0] hy);
      longint k0, step, ilow, scale, k, dd, q, r, bin, x, y;
      int idx;
      k0 = m_slope_low;
      step = longint'(m_slope_step);
      ilow = m_icpt_low;
      scale = longint'(m_icpt_scale);
      x = hx;
      y = hy;
      for (int j = 0; j < DefSlopeBins; j++) begin
         k = k0 + j * step;
         dd = y * 65536 - k * x - ilow * 65536;
         if (dd < 0) begin
            if (scale != 0) continue;
            bin = 0;
         end else begin
            q = dd >>> 16;
            r = dd & 65535;
            bin = (q * scale + ((r * scale) >>> 16)) >>> 16;
         end
         if (bin >= NumIcpt) continue;
         idx = j * NumIcpt + int'(bin);
         if (!vote_mem.exists(idx)) vote_mem[idx] = 16'd0;
         if (vote_mem[idx] != 16'hFFFF) vote_mem[idx] = vote_mem[idx] + 16'd1;
         if ($urandom_range(7) == 0) begin
            voted_cells = {voted_cells, idx};
            if (voted_cells.size() > 64) void'(voted_cells.pop_front());
         end
      end
   endtask

   // model effect of one accepted request
   task automatic apply_request(input logic [1:0] op, input logic [ReqDataW-1:0] d);
      int idx;
      case (op)
         OP_ADD: cast_votes(d[15:0], d[31:16]);
         OP_READ: begin
            idx = int'(d[42:32]) * NumIcpt + int'(d[50:43]);
            count_q = {count_q, (vote_mem.exists(idx) ? vote_mem[idx] : 16'd0)};
         end
         OP_CLEAR: begin
            vote_mem.delete();
            voted_cells.delete();
         end
         default: ;
      endcase
   endtask

   // request driver
   always @(posedge clock) begin
      hough_req_type it;
      int c;
      if (!reset && req_tvalid && req_tready) begin
         apply_request(req_tuser, req_tdata);
         xfer_count <= xfer_count + 1;
      end
      if (!reset && (!req_tvalid || req_tready)) begin
         if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 32)) begin
            it = pending_q.pop_front();
            if (it.hot && voted_cells.size() > 0) begin
               c = voted_cells[$urandom_range(voted_cells.size() - 1)];
               it.sb = SlopeBinW'(c / NumIcpt);
               it.ib = IcptBinW'(c % NumIcpt);
            end
            req_tvalid <= 1'b1;
            req_tuser  <= it.op;
            req_tdata  <= {5'd0, it.ib, it.sb, it.y, it.x};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (count_q.size() == 0) begin
            $error("unexpected transfer: cell_count actual %0d", rsp_tdata);
            fails++;
         end else begin
            if (rsp_tdata !== count_q[0]) begin
               $error("cell_count mismatch: expected %0d actual %0d", count_q[0], rsp_tdata);
               fails++;
            end
            void'(count_q.pop_front());
         end
      end
      if (hold_go && !hold_armed) begin
         hold_armed <= 1'b1;
         hold_left  <= 600;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 32);
      end
   end

   task automatic write_reg(input logic [CsrIndexW-1:0] idx, input logic [23:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      case (idx)
         CSR_SLOPE_LOW:  m_slope_low  = val;
         CSR_SLOPE_STEP: m_slope_step = val[22:0];
         CSR_ICPT_LOW:   m_icpt_low   = val[15:0];
         default:        m_icpt_scale = val[15:0];
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_regs(input int sl, input int ss, input int il, input int sc);
      write_reg(CSR_SLOPE_LOW, sl[23:0]);
      write_reg(CSR_SLOPE_STEP, ss[23:0]);
      write_reg(CSR_ICPT_LOW, il[23:0]);
      write_reg(CSR_ICPT_SCALE, sc[23:0]);
   endtask

   task automatic push_req(input logic [1:0] op, input int x, input int y,
                           input int sb, input int ib, input bit hot);
      hough_req_type it;
      it.op = op;
      it.x = x[15:0];
      it.y = y[15:0];
      it.sb = sb[10:0];
      it.ib = ib[7:0];
      it.hot = hot;
      pending_q = {pending_q, it};
   endtask

   // random mix: mostly reads, well-formed hits near the origin, some noise
   task automatic push_random(input int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 18)
            push_req(OP_ADD, $urandom_range(5120) - 2560, $urandom_range(5120) - 2560,
                     $urandom, $urandom, 0);
         else if (r < 24)
            push_req(OP_ADD, $urandom, $urandom, $urandom, $urandom, 0);
         else if (r < 28)
            push_req(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, 0);
         else if (r < 70)
            push_req(OP_READ, $urandom, $urandom, $urandom, $urandom, 1);
         else
            push_req(OP_READ, $urandom, $urandom, $urandom, $urandom, 0);
      end
      // trailing read waits behind any running sweep
      push_req(OP_READ, 0, 0, 0, 0, 1);
   endtask

   // wait until every request is sent and every result is back
   task automatic drain();
      @(posedge clock);
      while (pending_q.size() > 0 || req_tvalid || count_q.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      m_slope_low  = SlopeLowReset;
      m_slope_step = SlopeStepReset;
      m_icpt_low   = IcptLowReset;
      m_icpt_scale = IcptScaleReset;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, extreme coordinates, edge cells, clear
      set_regs(-6553600, 6554, -2560, 2560);
      push_req(OP_ADD, 0, 0, 0, 0, 0);
      push_req(OP_READ, 0, 0, 0, 100, 0);
      push_req(OP_READ, 0, 0, 2047, 100, 0);
      push_req(OP_ADD, 32767, -32768, 0, 0, 0);
      push_req(OP_ADD, -32768, 32767, 0, 0, 0);
      push_req(OP_ADD, 256, 256, 0, 0, 0);
      push_req(OP_ADD, -2560, -2560, 0, 0, 0);
      push_req(OP_READ, 0, 0, 0, 0, 0);
      push_req(OP_READ, 0, 0, 2047, 255, 0);
      push_req(OP_READ, 0, 0, 1023, 100, 0);
      push_req(OP_UNUSED, -1, -1, 2047, 255, 0);
      push_req(OP_READ, 0, 0, 0, 0, 1);
      push_req(OP_READ, 0, 0, 0, 0, 1);
      push_req(OP_READ, 0, 0, 0, 0, 1);
      push_req(OP_CLEAR, -1, -1, 2047, 255, 0);
      push_req(OP_READ, 0, 0, 0, 100, 0);
      push_req(OP_ADD, 256, 0, 0, 0, 0);
      push_req(OP_READ, 0, 0, 0, 0, 1);
      push_req(OP_READ, 0, 0, 0, 0, 1);
      drain();

      // zero scale with lowest edges: all votes in intercept bin zero
      set_regs(-8388608, 0, -32768, 0);
      push_req(OP_ADD, 512, -512, 0, 0, 0);
      push_req(OP_READ, 0, 0, 2047, 0, 0);
      push_random(60);
      drain();

      // top values, and a long receiver hold-off to back up the input
      set_regs(8388607, 8388607, 32767, 65535);
      hold_go <= 1'b1;
      push_random(70);
      drain();

      // random settings around the default
      for (int p = 0; p < 2; p++) begin
         set_regs($urandom_range(13107200) - 6553600, $urandom_range(20000),
                  $urandom_range(10240) - 5120, $urandom_range(8192));
         push_random(65);
         drain();
      end

      repeat (50) @(posedge clock);
      if (fails == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

### files.f
sv/lha_pkg.sv
sv/lha_ram.sv
sv/lha_front.sv
sv/lha_engine.sv
sv/line_hough_accumulator.sv
tb/tb.sv
